>>> hw/rtl/best_fit_partition_allocator_top_assert.svh
// Assertion macros for the best-fit partition allocator.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, disabled during reset.
`define BFPA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfpa assertion failed");

// Next-cycle implication, checked on clk, disabled during reset.
`define BFPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfpa assertion failed");

`endif

>>> hw/rtl/bfpa_pkg.sv
// Shared types and constants of the best-fit partition allocator.
package bfpa_pkg;

  localparam int FREE_ENTRIES_DEF = 16;
  localparam int USED_ENTRIES_DEF = 16;
  localparam int ADDR_W = 32;
  localparam int JOB_W = 8;
  localparam int ST_W = 3;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [ADDR_W-1:0] THR_RST = 32'd100;
  localparam logic [ADDR_W-1:0] BASE_RST = 32'd10240;
  localparam logic [ADDR_W-1:0] LEN_RST = 32'd102400;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN = 2'd2;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_RECLAIM = 1'b1;

  localparam logic [JOB_W-1:0] JOB_NONE = 8'd0;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 3'd1;
  localparam logic [ST_W-1:0] ST_USEDFULL = 3'd2;
  localparam logic [ST_W-1:0] ST_NOJOB = 3'd3;
  localparam logic [ST_W-1:0] ST_FREEFULL = 3'd4;

  // Scan table select
  localparam logic SEL_FREE = 1'b0;
  localparam logic SEL_USED = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [JOB_W-1:0]  job_id;
    logic [ADDR_W-1:0] request_length;
  } in_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] region_address;
    logic [ADDR_W-1:0] region_length;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic            ld;
    logic            scan_go;
    logic            scan_sel;
    logic            prep;
    logic            calc;
    logic            sum1;
    logic            sum2;
    logic            awr;
    logic            rwr;
    logic            out_ld;
    logic [ST_W-1:0] st;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic job_zero;
    logic rcl;
    logic bf;
    logic uf;
    logic nbr;
    logic sf;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/bfpa_dp.sv
// Datapath: region tables, scan unit, merge arithmetic and result register.
module bfpa_dp #(
  parameter int FREE_ENTRIES = bfpa_pkg::FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = bfpa_pkg::USED_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bfpa_pkg::in_t                     in_data,
  input  logic                              cfg_we,
  input  logic [bfpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfpa_pkg::ADDR_W-1:0]       cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output bfpa_pkg::out_t                    out_data,
  input  bfpa_pkg::dp_cmd_t                 cmd,
  output bfpa_pkg::dp_sts_t                 sts
);

  localparam int FI_W = $clog2(FREE_ENTRIES);
  localparam int UI_W = $clog2(USED_ENTRIES);
  localparam int MW = (FI_W > UI_W) ? FI_W : UI_W;
  localparam logic [MW-1:0] F_LAST = MW'(FREE_ENTRIES - 1);
  localparam logic [MW-1:0] U_LAST = MW'(USED_ENTRIES - 1);
  localparam int AW = bfpa_pkg::ADDR_W;

  // Configuration and valid bits
  logic [AW-1:0] thr_r, pbase_r, plen_r;
  logic e0_pool_r;
  logic [FREE_ENTRIES-1:0] free_vld_r;
  logic [USED_ENTRIES-1:0] used_vld_r;

  // Table memories
  logic [AW-1:0] free_st_mem [FREE_ENTRIES];
  logic [AW-1:0] free_sz_mem [FREE_ENTRIES];
  logic [bfpa_pkg::JOB_W-1:0] used_ow_mem [USED_ENTRIES];
  logic [AW-1:0] used_st_mem [USED_ENTRIES];
  logic [AW-1:0] used_sz_mem [USED_ENTRIES];
  logic [AW-1:0] fst_q, fsz_q, ust_q, usz_q;
  logic [bfpa_pkg::JOB_W-1:0] uow_q;

  // Latched item
  logic rcl_r;
  logic [bfpa_pkg::JOB_W-1:0] job_r;
  logic [AW-1:0] req_r;

  // Scan unit
  logic run_r, sel_r, p_r, plast_r, done_r;
  logic [MW-1:0] cnt_r, pidx_r;

  // Scan findings
  logic bf_r, uf_r, sf_r, ab_r, bl_r;
  logic [FI_W-1:0] bidx_r, sidx_r, aidx_r, blidx_r;
  logic [UI_W-1:0] uidx_r;
  logic [AW-1:0] bst_r, bsz_r, rs_r, rl_r, ast_r, asz_r, blsz_r, rend_r;
  logic [AW-1:0] diff_r, acc_r, res_addr_r, res_len_r;
  logic whole_r;

  logic out_valid_r;
  bfpa_pkg::out_t out_data_r;

  // Scanned entry view, entry 0 follows the pool registers until written
  logic [FI_W-1:0] pidx_f;
  logic [UI_W-1:0] pidx_u;
  logic [AW-1:0] cur_st, cur_sz, cur_end;
  logic cur_fv, cur_uv, blx;

  assign pidx_f = pidx_r[FI_W-1:0];
  assign pidx_u = pidx_r[UI_W-1:0];
  assign cur_st = (pidx_f == '0 && e0_pool_r) ? pbase_r : fst_q;
  assign cur_sz = (pidx_f == '0 && e0_pool_r) ? plen_r : fsz_q;
  assign cur_end = cur_st + cur_sz;
  assign cur_fv = free_vld_r[pidx_f];
  assign cur_uv = used_vld_r[pidx_u];
  // one entry touching both sides counts as the lower neighbor only
  assign blx = bl_r && !(ab_r && blidx_r == aidx_r);

  // Free table write port
  logic fw_en;
  logic [FI_W-1:0] fw_idx;
  logic [AW-1:0] fw_st, fw_sz, a_addr, a_len;

  assign a_addr = whole_r ? bst_r : bst_r + diff_r;
  assign a_len = whole_r ? bsz_r : req_r;

  always_comb begin
    fw_en = 1'b0;
    fw_idx = bidx_r;
    fw_st = bst_r;
    fw_sz = diff_r;
    if (cmd.awr) begin
      fw_en = !whole_r;
    end else if (cmd.rwr) begin
      if (ab_r) begin
        fw_en = 1'b1;
        fw_idx = aidx_r;
        fw_st = ast_r;
        fw_sz = acc_r;
      end else if (blx) begin
        fw_en = 1'b1;
        fw_idx = blidx_r;
        fw_st = rs_r;
        fw_sz = acc_r;
      end else if (sf_r) begin
        fw_en = 1'b1;
        fw_idx = sidx_r;
        fw_st = rs_r;
        fw_sz = rl_r;
      end
    end
  end

  // Memories: one write, one registered read at the scan address
  always_ff @(posedge clk) begin
    if (fw_en) begin
      free_st_mem[fw_idx] <= fw_st;
      free_sz_mem[fw_idx] <= fw_sz;
    end
    if (cmd.awr) begin
      used_ow_mem[uidx_r] <= job_r;
      used_st_mem[uidx_r] <= a_addr;
      used_sz_mem[uidx_r] <= a_len;
    end
    fst_q <= free_st_mem[cnt_r[FI_W-1:0]];
    fsz_q <= free_sz_mem[cnt_r[FI_W-1:0]];
    uow_q <= used_ow_mem[cnt_r[UI_W-1:0]];
    ust_q <= used_st_mem[cnt_r[UI_W-1:0]];
    usz_q <= used_sz_mem[cnt_r[UI_W-1:0]];
  end

  // Control state: config, valid bits, scan sequencing, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= bfpa_pkg::THR_RST;
      pbase_r <= bfpa_pkg::BASE_RST;
      plen_r <= bfpa_pkg::LEN_RST;
      e0_pool_r <= 1'b1;
      free_vld_r <= FREE_ENTRIES'(1);
      used_vld_r <= '0;
      run_r <= 1'b0;
      p_r <= 1'b0;
      done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index) inside
          bfpa_pkg::REG_THR: thr_r <= cfg_data;
          bfpa_pkg::REG_BASE, bfpa_pkg::REG_LEN: begin
            if (cfg_index == bfpa_pkg::REG_BASE) pbase_r <= cfg_data;
            else plen_r <= cfg_data;
            e0_pool_r <= 1'b1;
            free_vld_r <= FREE_ENTRIES'(1);
            used_vld_r <= '0;
          end
          default: ;
        endcase
      end
      if (fw_en && fw_idx == '0) e0_pool_r <= 1'b0;
      // commit updates to valid bits
      if (cmd.awr) begin
        used_vld_r[uidx_r] <= 1'b1;
        if (whole_r) free_vld_r[bidx_r] <= 1'b0;
      end
      if (cmd.rwr && (ab_r || blx || sf_r)) begin
        used_vld_r[uidx_r] <= 1'b0;
        if (ab_r && blx) free_vld_r[blidx_r] <= 1'b0;
        else if (!ab_r && !blx) free_vld_r[sidx_r] <= 1'b1;
      end
      // scan sequencing
      if (cmd.scan_go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == (sel_r ? U_LAST : F_LAST)) begin
        run_r <= 1'b0;
      end
      p_r <= run_r;
      done_r <= p_r && plast_r;
      // result register
      if (cmd.out_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      rcl_r <= in_data.cmd;
      job_r <= in_data.job_id;
      req_r <= in_data.request_length;
    end
    if (cmd.scan_go) begin
      cnt_r <= '0;
      sel_r <= cmd.scan_sel;
      if (cmd.scan_sel == bfpa_pkg::SEL_FREE) begin
        bf_r <= 1'b0;
        sf_r <= 1'b0;
        ab_r <= 1'b0;
        bl_r <= 1'b0;
      end else begin
        uf_r <= 1'b0;
      end
    end else if (run_r) begin
      cnt_r <= cnt_r + MW'(1);
    end
    pidx_r <= cnt_r;
    plast_r <= (cnt_r == (sel_r ? U_LAST : F_LAST));
    // one entry examined per cycle
    if (p_r && sel_r == bfpa_pkg::SEL_FREE) begin
      if (rcl_r == bfpa_pkg::CMD_ALLOC) begin
        if (cur_fv && cur_sz >= req_r && (!bf_r || cur_sz < bsz_r)) begin
          bf_r <= 1'b1;
          bidx_r <= pidx_f;
          bst_r <= cur_st;
          bsz_r <= cur_sz;
        end
      end else if (cur_fv && !(ab_r && bl_r)) begin
        if (cur_end == rs_r) begin
          ab_r <= 1'b1;
          aidx_r <= pidx_f;
          ast_r <= cur_st;
          asz_r <= cur_sz;
        end
        if (cur_st == rend_r) begin
          bl_r <= 1'b1;
          blidx_r <= pidx_f;
          blsz_r <= cur_sz;
        end
      end
      if (!cur_fv && !sf_r) begin
        sf_r <= 1'b1;
        sidx_r <= pidx_f;
      end
    end
    if (p_r && sel_r == bfpa_pkg::SEL_USED && !uf_r) begin
      if (rcl_r == bfpa_pkg::CMD_ALLOC) begin
        if (!cur_uv) begin
          uf_r <= 1'b1;
          uidx_r <= pidx_u;
        end
      end else if (cur_uv && uow_q == job_r) begin
        uf_r <= 1'b1;
        uidx_r <= pidx_u;
        rs_r <= ust_q;
        rl_r <= usz_q;
      end
    end
    // arithmetic steps
    if (cmd.prep) rend_r <= rs_r + rl_r;
    if (cmd.calc) begin
      diff_r <= bsz_r - req_r;
      whole_r <= (bsz_r - req_r) <= thr_r;
    end
    if (cmd.sum1) acc_r <= (ab_r ? asz_r : blsz_r) + rl_r;
    if (cmd.sum2 && ab_r && blx) acc_r <= acc_r + blsz_r;
    if (cmd.awr) begin
      res_addr_r <= a_addr;
      res_len_r <= a_len;
    end
    if (cmd.rwr) begin
      res_addr_r <= rs_r;
      res_len_r <= rl_r;
    end
    if (cmd.out_ld) begin
      out_data_r.status <= cmd.st;
      out_data_r.region_address <= (cmd.st == bfpa_pkg::ST_OK) ? res_addr_r : '0;
      out_data_r.region_length <= (cmd.st == bfpa_pkg::ST_OK) ? res_len_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign sts.scan_done = done_r;
  assign sts.job_zero = (job_r == bfpa_pkg::JOB_NONE);
  assign sts.rcl = rcl_r;
  assign sts.bf = bf_r;
  assign sts.uf = uf_r;
  assign sts.nbr = ab_r || blx;
  assign sts.sf = sf_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

>>> hw/rtl/bfpa_ctrl.sv
// Controller: sequences scans, arithmetic steps and table commits per item.
module bfpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfpa_pkg::dp_sts_t  sts,
  output bfpa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_AF, S_AU, S_ACALC, S_AWR,
    S_RU, S_RPREP, S_RF, S_RSUM1, S_RSUM2, S_RWR, S_DONE
  } state_t;

  state_t state_r;
  logic go_r, sel_r;
  logic [bfpa_pkg::ST_W-1:0] st_r;

  // State, scan start and result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r <= 1'b0;
      sel_r <= bfpa_pkg::SEL_FREE;
      st_r <= bfpa_pkg::ST_OK;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_CHK;
        S_CHK: begin
          if (sts.job_zero) begin
            st_r <= bfpa_pkg::ST_NOJOB;
            state_r <= S_DONE;
          end else begin
            go_r <= 1'b1;
            sel_r <= sts.rcl ? bfpa_pkg::SEL_USED : bfpa_pkg::SEL_FREE;
            state_r <= sts.rcl ? S_RU : S_AF;
          end
        end
        S_AF: if (sts.scan_done) begin
          if (!sts.bf) begin
            st_r <= bfpa_pkg::ST_NOFIT;
            state_r <= S_DONE;
          end else begin
            go_r <= 1'b1;
            sel_r <= bfpa_pkg::SEL_USED;
            state_r <= S_AU;
          end
        end
        S_AU: if (sts.scan_done) begin
          if (!sts.uf) begin
            st_r <= bfpa_pkg::ST_USEDFULL;
            state_r <= S_DONE;
          end else begin
            state_r <= S_ACALC;
          end
        end
        S_ACALC: state_r <= S_AWR;
        S_AWR: begin
          st_r <= bfpa_pkg::ST_OK;
          state_r <= S_DONE;
        end
        S_RU: if (sts.scan_done) begin
          if (!sts.uf) begin
            st_r <= bfpa_pkg::ST_NOJOB;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RPREP;
          end
        end
        S_RPREP: begin
          go_r <= 1'b1;
          sel_r <= bfpa_pkg::SEL_FREE;
          state_r <= S_RF;
        end
        S_RF: if (sts.scan_done) state_r <= S_RSUM1;
        S_RSUM1: state_r <= S_RSUM2;
        S_RSUM2: state_r <= S_RWR;
        S_RWR: begin
          st_r <= (sts.nbr || sts.sf) ? bfpa_pkg::ST_OK : bfpa_pkg::ST_FREEFULL;
          state_r <= S_DONE;
        end
        S_DONE: if (sts.out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Commands decoded from state
  assign cmd.ld = in_valid && in_ready;
  assign cmd.scan_go = go_r;
  assign cmd.scan_sel = sel_r;
  assign cmd.prep = (state_r == S_RPREP);
  assign cmd.calc = (state_r == S_ACALC);
  assign cmd.sum1 = (state_r == S_RSUM1);
  assign cmd.sum2 = (state_r == S_RSUM2);
  assign cmd.awr = (state_r == S_AWR);
  assign cmd.rwr = (state_r == S_RWR);
  assign cmd.out_ld = (state_r == S_DONE) && sts.out_free;
  assign cmd.st = st_r;

endmodule

>>> hw/rtl/best_fit_partition_allocator_top.sv
// Top level of the best-fit partition allocator with coalescing on reclaim.
// One item at a time: the next beat is taken in the cycle after the result loads, even while it
// still waits at the output; each scan reads one table entry a cycle.
// Reset (rst_n low, synchronous) restores registers, empties the used table and leaves the
// whole pool as the single free entry.
module best_fit_partition_allocator_top #(
  parameter int FREE_ENTRIES = bfpa_pkg::FREE_ENTRIES_DEF,
  parameter int USED_ENTRIES = bfpa_pkg::USED_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bfpa_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bfpa_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfpa_pkg::ADDR_W-1:0]    cfg_data
);

  bfpa_pkg::dp_cmd_t cmd;
  bfpa_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bfpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfpa_dp #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .USED_ENTRIES (USED_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `include "best_fit_partition_allocator_top_assert.svh"

  // result load never overwrites a beat still waiting
  `BFPA_ASSERT_IMPL(a_out_ld_free, cmd.out_ld, !out_valid || out_ready)
  // accepted item makes the block busy
  `BFPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a failed beat carries no region
  `BFPA_ASSERT_IMPL(a_fail_zero, out_valid && out_data.status != bfpa_pkg::ST_OK,
                    out_data.region_address == '0 && out_data.region_length == '0)

endmodule

>>> dv/best_fit_partition_allocator_top_tb.sv
// Self-checking testbench for the best-fit partition allocator top level.
`timescale 1ns / 100ps

module best_fit_partition_allocator_top_tb;

  localparam int NFREE = bfpa_pkg::FREE_ENTRIES_DEF;
  localparam int NUSED = bfpa_pkg::USED_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 2 * (NFREE + NUSED) + 20;
  localparam int AW = bfpa_pkg::ADDR_W;
  localparam int JW = bfpa_pkg::JOB_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bfpa_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bfpa_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bfpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [AW-1:0] cfg_data = '0;

  best_fit_partition_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: registers and both tables
  logic [AW-1:0] thr_q, base_q, len_q;
  logic [AW-1:0] fr_start [NFREE];
  logic [AW-1:0] fr_size [NFREE];
  logic fr_vld [NFREE];
  logic [AW-1:0] us_start [NUSED];
  logic [AW-1:0] us_size [NUSED];
  logic [JW-1:0] us_owner [NUSED];

  bfpa_pkg::in_t cmd_q[$];
  bfpa_pkg::out_t grant_q[$];
  int errors = 0;
  int n_out = 0;
  int n_ok = 0;
  int n_fail = 0;
  bit quiet = 1'b0;
  bit in_acc = 1'b0;

  function automatic void tables_init();
    for (int i = 0; i < NFREE; i++) begin
      fr_start[i] = '0; fr_size[i] = '0; fr_vld[i] = 1'b0;
    end
    for (int i = 0; i < NUSED; i++) begin
      us_start[i] = '0; us_size[i] = '0; us_owner[i] = bfpa_pkg::JOB_NONE;
    end
    fr_start[0] = base_q;
    fr_size[0] = len_q;
    fr_vld[0] = 1'b1;
  endfunction

  function automatic bfpa_pkg::out_t alloc_predict(logic [JW-1:0] job, logic [AW-1:0] req);
    bfpa_pkg::out_t r;
    int best;
    int slot;
    r = '0;
    best = -1;
    slot = -1;
    if (job == bfpa_pkg::JOB_NONE) begin
      r.status = bfpa_pkg::ST_NOJOB;
      return r;
    end
    for (int i = 0; i < NFREE; i++)
      if (fr_vld[i] && fr_size[i] >= req && (best < 0 || fr_size[i] < fr_size[best]))
        best = i;
    if (best < 0) begin
      r.status = bfpa_pkg::ST_NOFIT;
      return r;
    end
    for (int i = 0; i < NUSED; i++)
      if (slot < 0 && us_owner[i] == bfpa_pkg::JOB_NONE) slot = i;
    if (slot < 0) begin
      r.status = bfpa_pkg::ST_USEDFULL;
      return r;
    end
    if (fr_size[best] - req <= thr_q) begin
      fr_vld[best] = 1'b0;
      r.region_address = fr_start[best];
      r.region_length = fr_size[best];
    end else begin
      fr_size[best] = fr_size[best] - req;
      r.region_address = fr_start[best] + fr_size[best];
      r.region_length = req;
    end
    us_start[slot] = r.region_address;
    us_size[slot] = r.region_length;
    us_owner[slot] = job;
    r.status = bfpa_pkg::ST_OK;
    return r;
  endfunction

  function automatic bfpa_pkg::out_t reclaim_predict(logic [JW-1:0] job);
    bfpa_pkg::out_t r;
    int s, up, dn, t;
    logic [AW-1:0] rs, rl;
    r = '0;
    s = -1; up = -1; dn = -1; t = -1;
    r.status = bfpa_pkg::ST_NOJOB;
    if (job == bfpa_pkg::JOB_NONE) return r;
    for (int i = 0; i < NUSED; i++)
      if (s < 0 && us_owner[i] == job) s = i;
    if (s < 0) return r;
    rs = us_start[s];
    rl = us_size[s];
    for (int i = 0; i < NFREE && (up < 0 || dn < 0); i++)
      if (fr_vld[i]) begin
        if (fr_start[i] + fr_size[i] == rs) up = i;
        if (fr_start[i] == rs + rl) dn = i;
      end
    if (up >= 0 && dn == up) dn = -1;
    if (up >= 0) begin
      if (dn >= 0) begin
        fr_size[up] = fr_size[up] + fr_size[dn] + rl;
        fr_vld[dn] = 1'b0;
      end else begin
        fr_size[up] = fr_size[up] + rl;
      end
    end else if (dn >= 0) begin
      fr_start[dn] = rs;
      fr_size[dn] = fr_size[dn] + rl;
    end else begin
      for (int i = 0; i < NFREE; i++)
        if (t < 0 && !fr_vld[i]) t = i;
      if (t < 0) begin
        r.status = bfpa_pkg::ST_FREEFULL;
        return r;
      end
      fr_start[t] = rs;
      fr_size[t] = rl;
      fr_vld[t] = 1'b1;
    end
    us_owner[s] = bfpa_pkg::JOB_NONE;
    r.status = bfpa_pkg::ST_OK;
    r.region_address = rs;
    r.region_length = rl;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [AW-1:0] got, logic [AW-1:0] exp);
    errors++;
    if (errors <= 40)
      $display("MISMATCH beat %0d %s: got 0x%08h exp 0x%08h", n_out, what, got, exp);
  endtask

  // Input accept: predict the beat taken at this edge and retire it from the queue
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (in_data.cmd == bfpa_pkg::CMD_ALLOC)
        grant_q.push_back(alloc_predict(in_data.job_id, in_data.request_length));
      else
        grant_q.push_back(reclaim_predict(in_data.job_id));
      void'(cmd_q.pop_front());
      in_acc = 1'b1;
    end
  end

  // Driver: presents the oldest pending item, drops valid after acceptance when idling
  always @(negedge clk) begin
    if (rst_n && !cfg_valid && (!in_valid || in_acc) && cmd_q.size() > 0 &&
        (quiet || $urandom_range(99) >= 10)) begin
      in_data <= cmd_q[0];
      in_valid <= 1'b1;
    end else if (in_acc) begin
      in_valid <= 1'b0;
    end
    in_acc = 1'b0;
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    bfpa_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected beat", AW'(out_data.status), '0);
      end else begin
        e = grant_q.pop_front();
        if (out_data.status != e.status)
          report_mismatch("status", AW'(out_data.status), AW'(e.status));
        if (out_data.region_address != e.region_address)
          report_mismatch("address", out_data.region_address, e.region_address);
        if (out_data.region_length != e.region_length)
          report_mismatch("length", out_data.region_length, e.region_length);
        if (e.status == bfpa_pkg::ST_OK) n_ok++; else n_fail++;
      end
    end
  end

  always @(negedge clk)
    out_ready <= quiet || ($urandom_range(99) >= 10);

  task automatic push(logic cmd, logic [JW-1:0] job, logic [AW-1:0] req);
    bfpa_pkg::in_t it;
    it.cmd = cmd; it.job_id = job; it.request_length = req;
    cmd_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (cmd_q.size() > 0 || in_valid || grant_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bfpa_pkg::CFG_IDX_W-1:0] idx, logic [AW-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bfpa_pkg::REG_THR) thr_q = val;
    else if (idx == bfpa_pkg::REG_BASE) begin base_q = val; tables_init(); end
    else if (idx == bfpa_pkg::REG_LEN) begin len_q = val; tables_init(); end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random phase: mostly allocate/reclaim of job ids 1 to 24, sizes scaled by the scale argument
  task automatic random_phase(int n, logic [AW-1:0] scale);
    logic [AW-1:0] req;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: req = $urandom();
        1: req = '0;
        default: req = (scale == 0) ? $urandom_range(3) : $urandom_range(scale);
      endcase
      if ($urandom_range(1)) push(bfpa_pkg::CMD_ALLOC, JW'($urandom_range(1, 24)), req);
      else if ($urandom_range(9) == 0) push(bfpa_pkg::CMD_RECLAIM, JW'($urandom()), $urandom());
      else push(bfpa_pkg::CMD_RECLAIM, JW'($urandom_range(1, 24)), req);
    end
  endtask

  initial begin
    thr_q = bfpa_pkg::THR_RST; base_q = bfpa_pkg::BASE_RST; len_q = bfpa_pkg::LEN_RST;
    tables_init();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: refusals, splits, whole grants, coalescing, table full cases
    push(bfpa_pkg::CMD_ALLOC, bfpa_pkg::JOB_NONE, 32'd10);
    push(bfpa_pkg::CMD_RECLAIM, bfpa_pkg::JOB_NONE, '0);
    push(bfpa_pkg::CMD_RECLAIM, 8'd5, '0);
    push(bfpa_pkg::CMD_ALLOC, 8'd255, 32'hFFFF_FFFF);
    push(bfpa_pkg::CMD_ALLOC, 8'd1, 32'd1000);
    push(bfpa_pkg::CMD_ALLOC, 8'd2, 32'd0);
    push(bfpa_pkg::CMD_ALLOC, 8'd3, 32'd2000);
    push(bfpa_pkg::CMD_ALLOC, 8'd3, 32'd500);
    push(bfpa_pkg::CMD_RECLAIM, 8'd2, 32'hFFFF_FFFF);
    push(bfpa_pkg::CMD_RECLAIM, 8'd3, '0);
    push(bfpa_pkg::CMD_RECLAIM, 8'd1, '0);
    push(bfpa_pkg::CMD_RECLAIM, 8'd3, '0);
    push(bfpa_pkg::CMD_ALLOC, 8'd4, 32'd102350);
    push(bfpa_pkg::CMD_RECLAIM, 8'd4, '0);
    for (int j = 1; j <= 17; j++) push(bfpa_pkg::CMD_ALLOC, 8'(j + 100), 32'd16);
    wait_idle();

    // Fragment the pool into separate free entries, then coalesce them back
    write_reg(bfpa_pkg::REG_THR, 32'd0);
    write_reg(bfpa_pkg::REG_LEN, 32'd4000);
    for (int j = 1; j <= 16; j++) push(bfpa_pkg::CMD_ALLOC, 8'(j), 32'd100);
    for (int j = 1; j <= 16; j += 2) push(bfpa_pkg::CMD_RECLAIM, 8'(j), '0);
    for (int j = 2; j <= 16; j += 2) push(bfpa_pkg::CMD_RECLAIM, 8'(j), '0);
    wait_idle();

    // Random under several settings, extremes included
    write_reg(bfpa_pkg::REG_BASE, 32'hFFFF_F000);
    write_reg(bfpa_pkg::REG_LEN, 32'h0000_2000);
    write_reg(bfpa_pkg::REG_THR, 32'hFFFF_FFFF);
    random_phase(120, 32'h400);
    wait_idle();
    write_reg(bfpa_pkg::REG_THR, 32'd0);
    write_reg(bfpa_pkg::REG_BASE, '0);
    write_reg(bfpa_pkg::REG_LEN, 32'hFFFF_FFFF);
    random_phase(200, 32'h0FFF_FFFF);
    wait_idle();
    write_reg(bfpa_pkg::REG_LEN, '0);
    random_phase(60, 0);
    wait_idle();
    write_reg(bfpa_pkg::REG_THR, bfpa_pkg::THR_RST);
    write_reg(bfpa_pkg::REG_BASE, bfpa_pkg::BASE_RST);
    write_reg(bfpa_pkg::REG_LEN, bfpa_pkg::LEN_RST);
    quiet = 1'b1;
    random_phase(200, 32'd8000);
    wait_idle();
    quiet = 1'b0;
    write_reg(bfpa_pkg::REG_THR, 32'd40);
    random_phase(380, 32'd12000);
    wait_idle();

    $display("Covered %0d result beats: %0d ok, %0d refused, over several register settings.",
             n_out, n_ok, n_fail);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("best_fit_partition_allocator_top_tb passed");
    end else begin
      $display("best_fit_partition_allocator_top_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("best_fit_partition_allocator_top_tb failed");
    $finish;
  end

endmodule
